// ===== rtl/jjd_pkg.sv =====
// Shared constants, types and helpers for the joint jam detector.
package jjd_pkg;

  // Block sizing. WINDOW must be a power of two (average is a shift).
  localparam int NUM_JOINTS = 20;
  localparam int WINDOW     = 16;

  // Fixed field widths.
  localparam int JOINT_W  = 5;
  localparam int SAMPLE_W = 13;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Derived widths.
  localparam int LOG2_W     = $clog2(WINDOW);
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + LOG2_W;
  localparam int RING_DEPTH = NUM_JOINTS * WINDOW;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int STATE_AW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  typedef logic [JOINT_W-1:0]         joint_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [FILL_W-1:0]          fill_t;
  typedef logic [RING_AW-1:0]         ring_addr_t;
  typedef logic [STATE_AW-1:0]        state_addr_t;

  // Transition codes reported per result.
  typedef enum logic [1:0] {
    TRANS_NONE     = 2'd0,
    TRANS_JAMMED   = 2'd1,
    TRANS_RELEASED = 2'd2
  } trans_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_LOW_THRESHOLD  = 1'b0,
    REG_HIGH_THRESHOLD = 1'b1
  } reg_idx_t;

  // Per-joint state kept in the state memory.
  typedef struct packed {
    sum_t sum;
    logic trig;
  } joint_state_t;

  // State memory write port.
  typedef struct packed {
    logic         we;
    state_addr_t  addr;
    joint_state_t data;
  } state_wr_t;

  // Trigger thresholds from the register block.
  typedef struct packed {
    sample_t low;
    sample_t high;
  } thresholds_t;

  // Ring memory address: joint row, slot within the window.
  function automatic ring_addr_t ring_addr(state_addr_t j, slot_t s);
    return RING_AW'(int'(j) * WINDOW + int'(s));
  endfunction

endpackage

// ===== rtl/jjd_in_if.sv =====
// Sample stream channel: joint index and position error.
interface jjd_in_if;
  logic             valid;
  logic             ready;
  jjd_pkg::joint_t  joint_index;
  jjd_pkg::sample_t position_error;

  modport source (output valid, joint_index, position_error, input ready);
  modport sink   (input valid, joint_index, position_error, output ready);
endinterface

// ===== rtl/jjd_out_if.sv =====
// Result stream channel: average, window state and trigger report.
interface jjd_out_if;
  logic              valid;
  logic              ready;
  jjd_pkg::joint_t   joint_out;
  jjd_pkg::sample_t  window_average;
  logic              window_full;
  jjd_pkg::trans_t   transition;
  logic              jammed;

  modport source (output valid, joint_out, window_average, window_full, transition, jammed,
                  input ready);
  modport sink   (input valid, joint_out, window_average, window_full, transition, jammed,
                  output ready);
endinterface

// ===== rtl/joint_jam_detector_unit.sv =====
// Top level of the joint jam detector: pipeline control and trigger logic.
//
// Usage: samples (joint_index, position_error) enter on a valid/ready stream;
// each transfer yields exactly one result on the results stream, in order.
// Thresholds are written through the APB-style port: low at 0x0, high at 0x4.
// A result passes through the stage 1 register and the output register before
// it is presented on the results stream.
// Throughput: one sample per cycle while results.ready is high. Per-joint sums
// live in a registered-read memory with a write bypass, so samples of the same
// joint may follow each other back to back. The oldest sample of a window
// is read from the ring memory in the same cycle the new one is written.
// Stalls: when results.ready is low the result register holds; if stage 1 is
// empty, one more sample is still taken into it, after which samples.ready
// drops until the result is taken.
// Reset: all joints start empty and not jammed; thresholds go to 0 and 4095.
// samples.ready is low while rst is high.
// Ring contents are not cleared; a slot is read only once it has been written.
// Samples with a joint index out of range change nothing and report zeros.
module joint_jam_detector_unit (
  input  logic                        clk,
  input  logic                        rst,
  jjd_in_if.sink                      samples,
  jjd_out_if.source                   results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jjd_pkg::PADDR_W-1:0] paddr,
  input  logic [jjd_pkg::PDATA_W-1:0] pwdata,
  output logic [jjd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  jjd_pkg::thresholds_t  thr;

  // Stage 0 signals
  logic                  accept;
  logic                  in_range;
  logic                  do_update;
  jjd_pkg::state_addr_t  jaddr;
  jjd_pkg::slot_t        cur_slot;
  jjd_pkg::fill_t        cur_fill;
  jjd_pkg::fill_t        fill_next;
  jjd_pkg::slot_t        slot_next;
  logic                  full_before;
  jjd_pkg::slot_t        slot_q [jjd_pkg::NUM_JOINTS];
  jjd_pkg::fill_t        fill_q [jjd_pkg::NUM_JOINTS];

  // Stage 1 registers and logic
  logic                  s1_valid;
  logic                  s1_adv;
  jjd_pkg::joint_t       s1_joint;
  logic                  s1_in_range;
  jjd_pkg::sample_t      s1_sample;
  logic                  s1_full_before;
  logic                  s1_full_after;
  jjd_pkg::sample_t      ring_old;
  jjd_pkg::joint_state_t st;
  jjd_pkg::state_wr_t    st_wr;
  jjd_pkg::sum_t         sum_new;
  jjd_pkg::sum_t         sum_adj;
  jjd_pkg::sum_t         avg_wide;
  jjd_pkg::sample_t      avg;
  logic                  trig_new;
  jjd_pkg::trans_t       trans;

  // Output register
  logic                  out_valid;

  jjd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // Handshake
  assign s1_adv        = !out_valid || results.ready;
  assign samples.ready = !rst && (!s1_valid || s1_adv);
  assign accept        = samples.valid && samples.ready;

  // Stage 0: slot and fill bookkeeping
  assign in_range    = int'(samples.joint_index) < jjd_pkg::NUM_JOINTS;
  assign do_update   = accept && in_range;
  assign jaddr       = jjd_pkg::STATE_AW'(samples.joint_index);
  assign cur_slot    = slot_q[jaddr];
  assign cur_fill    = fill_q[jaddr];
  assign full_before = (cur_fill == jjd_pkg::FILL_W'(jjd_pkg::WINDOW));
  assign fill_next   = full_before ? cur_fill : jjd_pkg::FILL_W'(cur_fill + 1'b1);
  assign slot_next   = (cur_slot == jjd_pkg::SLOT_W'(jjd_pkg::WINDOW - 1)) ? '0
                       : jjd_pkg::SLOT_W'(cur_slot + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < jjd_pkg::NUM_JOINTS; k++) begin
        slot_q[k] <= '0;
        fill_q[k] <= '0;
      end
    end else if (do_update) begin
      slot_q[jaddr] <= slot_next;
      fill_q[jaddr] <= fill_next;
    end
  end

  jjd_ring_mem u_ring (
    .clk   (clk),
    .en    (do_update),
    .addr  (jjd_pkg::ring_addr(jaddr, cur_slot)),
    .wdata (samples.position_error),
    .rdata (ring_old)
  );

  jjd_state_mem u_state (
    .clk   (clk),
    .rst   (rst),
    .re    (do_update),
    .raddr (jaddr),
    .wr    (st_wr),
    .rdata (st)
  );

  // Stage 1 pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_joint       <= samples.joint_index;
      s1_in_range    <= in_range;
      s1_sample      <= samples.position_error;
      s1_full_before <= full_before;
      s1_full_after  <= (fill_next == jjd_pkg::FILL_W'(jjd_pkg::WINDOW));
    end
  end

  // Running sum update and truncating average
  assign sum_new  = st.sum + jjd_pkg::sum_t'(s1_sample)
                    - (s1_full_before ? jjd_pkg::sum_t'(ring_old) : '0);
  assign sum_adj  = sum_new + (sum_new[jjd_pkg::SUM_W-1]
                    ? jjd_pkg::SUM_W'(jjd_pkg::WINDOW - 1) : '0);
  assign avg_wide = sum_adj >>> jjd_pkg::LOG2_W;
  assign avg      = avg_wide[jjd_pkg::SAMPLE_W-1:0];

  // Schmitt trigger, only once the window is full
  always_comb begin
    trig_new = st.trig;
    trans    = jjd_pkg::TRANS_NONE;
    if (s1_full_after) begin
      if (!st.trig && (avg > thr.high)) begin
        trig_new = 1'b1;
        trans    = jjd_pkg::TRANS_JAMMED;
      end else if (st.trig && (avg < thr.low)) begin
        trig_new = 1'b0;
        trans    = jjd_pkg::TRANS_RELEASED;
      end
    end
  end

  // State write-back as the item leaves stage 1
  assign st_wr.we        = s1_valid && s1_in_range && s1_adv;
  assign st_wr.addr      = jjd_pkg::STATE_AW'(s1_joint);
  assign st_wr.data.sum  = sum_new;
  assign st_wr.data.trig = trig_new;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      results.joint_out <= s1_joint;
      if (s1_in_range) begin
        results.window_average <= avg;
        results.window_full    <= s1_full_after;
        results.transition     <= trans;
        results.jammed         <= trig_new;
      end else begin
        results.window_average <= '0;
        results.window_full    <= 1'b0;
        results.transition     <= jjd_pkg::TRANS_NONE;
        results.jammed         <= 1'b0;
      end
    end
  end

  assign results.valid = out_valid;

  // Assertions
  a_trans_needs_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (results.transition != jjd_pkg::TRANS_NONE) |-> results.window_full)
    else $error("transition reported on a joint whose window is not full");

  a_jam_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (results.transition == jjd_pkg::TRANS_JAMMED) |-> results.jammed)
    else $error("jammed transition without jammed level");

  a_release_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && (results.transition == jjd_pkg::TRANS_RELEASED) |-> !results.jammed)
    else $error("released transition with jammed level");

  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv |=> out_valid)
    else $error("item left stage 1 without reaching the output register");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    do_update |-> cur_fill <= jjd_pkg::FILL_W'(jjd_pkg::WINDOW))
    else $error("fill count beyond window length");

endmodule

// ===== rtl/jjd_cfg_regs.sv =====
// APB-style register block holding the trigger thresholds.
module jjd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jjd_pkg::PADDR_W-1:0]   paddr,
  input  logic [jjd_pkg::PDATA_W-1:0]   pwdata,
  output logic [jjd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output jjd_pkg::thresholds_t          thr
);

  jjd_pkg::reg_idx_t idx;
  logic              wr_en;

  // Word aligned: byte lane bits are ignored
  assign idx    = jjd_pkg::reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.low  <= 13'sd0;
      thr.high <= 13'sd4095;
    end else if (wr_en) begin
      unique case (idx)
        jjd_pkg::REG_LOW_THRESHOLD:  thr.low  <= pwdata[jjd_pkg::SAMPLE_W-1:0];
        jjd_pkg::REG_HIGH_THRESHOLD: thr.high <= pwdata[jjd_pkg::SAMPLE_W-1:0];
      endcase
    end
  end

  // Readback, sign extended
  always_comb begin
    unique case (idx)
      jjd_pkg::REG_LOW_THRESHOLD:
        prdata = {{(jjd_pkg::PDATA_W-jjd_pkg::SAMPLE_W){thr.low[jjd_pkg::SAMPLE_W-1]}},
                  thr.low};
      jjd_pkg::REG_HIGH_THRESHOLD:
        prdata = {{(jjd_pkg::PDATA_W-jjd_pkg::SAMPLE_W){thr.high[jjd_pkg::SAMPLE_W-1]}},
                  thr.high};
    endcase
  end

endmodule

// ===== rtl/jjd_ring_mem.sv =====
// Sample ring memory: one row of WINDOW samples per joint, read-before-write.
module jjd_ring_mem (
  input  logic                clk,
  input  logic                en,
  input  jjd_pkg::ring_addr_t addr,
  input  jjd_pkg::sample_t    wdata,
  output jjd_pkg::sample_t    rdata
);

  jjd_pkg::sample_t mem [jjd_pkg::RING_DEPTH];

  // Oldest sample comes out as the new one goes into the same slot
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

// ===== rtl/jjd_state_mem.sv =====
// Per-joint sum and trigger memory with valid bits and write bypass.
module jjd_state_mem (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  re,
  input  jjd_pkg::state_addr_t  raddr,
  input  jjd_pkg::state_wr_t    wr,
  output jjd_pkg::joint_state_t rdata
);

  jjd_pkg::joint_state_t mem [jjd_pkg::NUM_JOINTS];
  logic [jjd_pkg::NUM_JOINTS-1:0] valid;
  jjd_pkg::joint_state_t rd_raw;
  jjd_pkg::joint_state_t byp_data;
  logic                  byp;
  logic                  vld_r;

  // Array write and registered read
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    if (re) begin
      rd_raw   <= mem[raddr];
      byp_data <= wr.data;
    end
  end

  // Valid bits and read select flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      byp   <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      if (wr.we) valid[wr.addr] <= 1'b1;
      if (re) begin
        byp   <= wr.we && (wr.addr == raddr);
        vld_r <= valid[raddr];
      end
    end
  end

  // Same-edge write wins; never written reads as reset value
  assign rdata = byp ? byp_data : (vld_r ? rd_raw : '0);

endmodule
